### hw/rtl/vqm_pkg.sv
// Shared types and constants of the virtqueue request chain manager.
// No dependencies; every other file imports this package.
package vqm_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int PENDING_SLOTS = 16;
    localparam int IDX_W  = 6;
    localparam int SLOT_W = 4;
    localparam int CNT_W  = 7;

    // configuration register indexes
    localparam logic [1:0] REG_QUEUE_SIZE  = 2'd0;
    localparam logic [1:0] REG_HEADER_BASE = 2'd1;
    localparam logic [1:0] REG_STATUS_BASE = 2'd2;

    // input opcodes
    localparam logic OP_SUBMIT   = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    // result kinds
    localparam logic [2:0] RK_HEADER    = 3'd0;
    localparam logic [2:0] RK_DESC      = 3'd1;
    localparam logic [2:0] RK_AVAIL     = 3'd2;
    localparam logic [2:0] RK_REFUSED   = 3'd3;
    localparam logic [2:0] RK_DONE      = 3'd4;
    localparam logic [2:0] RK_UNMATCHED = 3'd5;

    // descriptor flags
    localparam logic [1:0] DF_NEXT       = 2'd1;
    localparam logic [1:0] DF_WRITE      = 2'd2;
    localparam logic [1:0] DF_NEXT_WRITE = 2'd3;

    typedef enum logic [11:0] {
        ST_SWEEP = 12'b0000_0000_0001,
        ST_IDLE  = 12'b0000_0000_0010,
        ST_A0    = 12'b0000_0000_0100,
        ST_A1    = 12'b0000_0000_1000,
        ST_A2    = 12'b0000_0001_0000,
        ST_W0    = 12'b0000_0010_0000,
        ST_W1    = 12'b0000_0100_0000,
        ST_W2    = 12'b0000_1000_0000,
        ST_EMIT  = 12'b0001_0000_0000,
        ST_FWALK = 12'b0010_0000_0000,
        ST_DONE  = 12'b0100_0000_0000,
        ST_SPARE = 12'b1000_0000_0000
    } t_state;

    typedef struct packed {
        logic [2:0]        result_kind;
        logic [IDX_W-1:0]  desc_index;
        logic [63:0]       buf_addr;
        logic [31:0]       buf_len;
        logic [1:0]        desc_flags;
        logic [IDX_W-1:0]  next_index;
        logic              request_type;
        logic [SLOT_W-1:0] request_slot;
        logic              io_error;
        logic [15:0]       ring_position;
        logic              last;
    } t_rsp;

endpackage

### hw/rtl/vqm_req_if.sv
// Request channel: valid/ready handshake carrying one input word.
// Depends on vqm_pkg for widths.
interface vqm_req_if import vqm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic              is_write;
    logic [63:0]       sector;
    logic [63:0]       data_addr;
    logic [31:0]       data_len;
    logic [IDX_W-1:0]  used_id;
    logic [7:0]        device_status;

    modport source (output valid, opcode, is_write, sector, data_addr, data_len,
                    used_id, device_status, input ready);
    modport sink   (input valid, opcode, is_write, sector, data_addr, data_len,
                    used_id, device_status, output ready);
endinterface

### hw/rtl/vqm_rsp_if.sv
// Result channel: valid/ready handshake carrying one result word.
// Depends on vqm_pkg for widths.
interface vqm_rsp_if import vqm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        result_kind;
    logic [IDX_W-1:0]  desc_index;
    logic [63:0]       buf_addr;
    logic [31:0]       buf_len;
    logic [1:0]        desc_flags;
    logic [IDX_W-1:0]  next_index;
    logic              request_type;
    logic [SLOT_W-1:0] request_slot;
    logic              io_error;
    logic [15:0]       ring_position;
    logic              last;

    modport source (output valid, result_kind, desc_index, buf_addr, buf_len, desc_flags,
                    next_index, request_type, request_slot, io_error, ring_position, last,
                    input ready);
    modport sink   (input valid, result_kind, desc_index, buf_addr, buf_len, desc_flags,
                    next_index, request_type, request_slot, io_error, ring_position, last,
                    output ready);
endinterface

### hw/rtl/virtqueue_request_chain_manager.sv
// Driver-side split virtqueue engine: allocates 3-descriptor chains for block
// requests and walks them back onto the free list on completion.
// Depends on vqm_pkg, vqm_req_if and vqm_rsp_if.
//
// Descriptor links and chain flags live in two 64-entry synchronous RAMs.
// A submit passes, plus output stalls, through the accept cycle, three
// dependent RAM reads to pop the free list, three RAM writes for the chain,
// then five result words before the next acceptance. A refused submit or an
// unmatched completion gives a single word, valid the cycle after
// acceptance. A matched completion walks the chain one descriptor a cycle
// and then gives its done word. After reset and after each queue_size write
// a clearing pass over all 64 entries rebuilds the free list; no item is
// accepted during it. Registers sit at byte addresses 0, 8 and 16 (64-bit
// data).
module virtqueue_request_chain_manager import vqm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vqm_req_if.sink     i_req,
    vqm_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_qsz_raw, n_qsz_raw;
    logic [CNT_W-1:0]   r_qsz, n_qsz;
    logic [63:0]        r_hdr_base, n_hdr_base;
    logic [63:0]        r_sts_base, n_sts_base;
    logic [IDX_W-1:0]   r_flist_top, n_flist_top;
    logic [CNT_W-1:0]   r_free_cnt, n_free_cnt;
    logic [15:0]        r_avail, n_avail;
    logic [15:0]        r_used, n_used;
    logic [PENDING_SLOTS-1:0] r_busy, n_busy;
    logic [IDX_W-1:0]   r_slot_head [PENDING_SLOTS];
    logic               head_we;
    logic [CNT_W-1:0]   r_sweep, n_sweep;
    logic [IDX_W-1:0]   r_h0, n_h0, r_h1, n_h1, r_h2, n_h2;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic               r_wr, n_wr;
    logic [63:0]        r_sector, n_sector;
    logic [63:0]        r_daddr, n_daddr;
    logic [31:0]        r_dlen, n_dlen;
    logic [2:0]         r_step, n_step;
    logic [IDX_W-1:0]   r_walk, n_walk;
    logic [IDX_W-1:0]   r_steps, n_steps;
    logic               r_err, n_err;
    t_rsp               r_out, n_out;
    logic               r_ovalid, n_ovalid;

    // descriptor RAMs
    logic [IDX_W-1:0]   lk_mem [QUEUE_DEPTH];
    logic [1:0]         fl_mem [QUEUE_DEPTH];
    logic               lk_we, fl_we;
    logic [IDX_W-1:0]   mem_wa, mem_ra, lk_wd;
    logic [1:0]         fl_wd;
    logic [IDX_W-1:0]   r_lk_q;
    logic [1:0]         r_fl_q;
    logic               r_fwd;
    logic [IDX_W-1:0]   r_fwd_d;
    logic [IDX_W-1:0]   lk_rd;

    logic               can_load, in_acc, cfg_we;
    logic [1:0]         cfg_idx;
    logic               slot_found, match_found;
    logic [SLOT_W-1:0]  free_slot, match_slot;
    logic [CNT_W-1:0]   sweep_inc, wr_clamp;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:3];

    // register readback
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_QUEUE_SIZE:  prdata = {{(64-CNT_W){1'b0}}, r_qsz_raw};
            REG_HEADER_BASE: prdata = r_hdr_base;
            REG_STATUS_BASE: prdata = r_sts_base;
            default:         prdata = '0;
        endcase
    end

    assign can_load    = !r_ovalid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && can_load;
    assign in_acc      = i_req.valid && i_req.ready;

    // link read data, with the write of the previous cycle forwarded
    assign lk_rd = r_fwd ? r_fwd_d : r_lk_q;

    // lowest free slot and lowest busy slot whose head matches
    always_comb begin
        slot_found  = 1'b0;
        free_slot   = '0;
        match_found = 1'b0;
        match_slot  = '0;
        for (int s = PENDING_SLOTS - 1; s >= 0; s--) begin
            if (!r_busy[s]) begin
                slot_found = 1'b1;
                free_slot  = SLOT_W'(s);
            end
            if (r_busy[s] && r_slot_head[s] == i_req.used_id) begin
                match_found = 1'b1;
                match_slot  = SLOT_W'(s);
            end
        end
    end

    assign sweep_inc = r_sweep + CNT_W'(1);

    always_comb begin
        wr_clamp = pwdata[CNT_W-1:0];
        if (wr_clamp == '0) begin
            wr_clamp = CNT_W'(1);
        end else if (wr_clamp > CNT_W'(QUEUE_DEPTH)) begin
            wr_clamp = CNT_W'(QUEUE_DEPTH);
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_qsz_raw   = r_qsz_raw;
        n_qsz       = r_qsz;
        n_hdr_base  = r_hdr_base;
        n_sts_base  = r_sts_base;
        n_flist_top = r_flist_top;
        n_free_cnt  = r_free_cnt;
        n_avail     = r_avail;
        n_used      = r_used;
        n_busy      = r_busy;
        head_we     = 1'b0;
        n_sweep     = r_sweep;
        n_h0        = r_h0;
        n_h1        = r_h1;
        n_h2        = r_h2;
        n_slot      = r_slot;
        n_wr        = r_wr;
        n_sector    = r_sector;
        n_daddr     = r_daddr;
        n_dlen      = r_dlen;
        n_step      = r_step;
        n_walk      = r_walk;
        n_steps     = r_steps;
        n_err       = r_err;
        n_out       = r_out;
        n_ovalid    = r_ovalid && !o_rsp.ready;
        lk_we       = 1'b0;
        fl_we       = 1'b0;
        mem_wa      = r_sweep[IDX_W-1:0];
        mem_ra      = r_walk;
        lk_wd       = '0;
        fl_wd       = '0;

        unique case (r_state)
            ST_SWEEP: begin
                lk_we  = 1'b1;
                fl_we  = 1'b1;
                lk_wd  = (sweep_inc < r_qsz) ? sweep_inc[IDX_W-1:0] : '0;
                n_sweep = sweep_inc;
                if (r_sweep == CNT_W'(QUEUE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_out    = '0;
                    n_ovalid = 1'b0;
                    if (i_req.opcode == OP_SUBMIT) begin
                        if (!slot_found || r_free_cnt < CNT_W'(3)) begin
                            n_out.result_kind = RK_REFUSED;
                            n_out.last        = 1'b1;
                            n_ovalid          = 1'b1;
                        end else begin
                            n_slot   = free_slot;
                            n_wr     = i_req.is_write;
                            n_sector = i_req.sector;
                            n_daddr  = i_req.data_addr;
                            n_dlen   = i_req.data_len;
                            n_h0     = r_flist_top;
                            mem_ra   = r_flist_top;
                            n_state  = ST_A0;
                        end
                    end else begin
                        n_used = r_used + 16'd1;
                        n_err  = i_req.device_status != 8'd0;
                        n_walk = i_req.used_id;
                        if (!match_found) begin
                            n_out.result_kind = RK_UNMATCHED;
                            n_out.desc_index  = i_req.used_id;
                            n_out.last        = 1'b1;
                            n_ovalid          = 1'b1;
                        end else begin
                            n_slot  = match_slot;
                            n_busy[match_slot] = 1'b0;
                            n_steps = '0;
                            mem_ra  = i_req.used_id;
                            n_state = ST_FWALK;
                        end
                    end
                end
            end
            // pop three descriptors off the free list
            ST_A0: begin
                n_h1    = lk_rd;
                mem_ra  = lk_rd;
                n_state = ST_A1;
            end
            ST_A1: begin
                n_h2    = lk_rd;
                mem_ra  = lk_rd;
                n_state = ST_A2;
            end
            ST_A2: begin
                n_flist_top = lk_rd;
                n_free_cnt  = r_free_cnt - CNT_W'(3);
                n_state     = ST_W0;
            end
            // link the chain: header, data, status
            ST_W0: begin
                lk_we   = 1'b1;
                fl_we   = 1'b1;
                mem_wa  = r_h0;
                lk_wd   = r_h1;
                fl_wd   = DF_NEXT;
                n_state = ST_W1;
            end
            ST_W1: begin
                lk_we   = 1'b1;
                fl_we   = 1'b1;
                mem_wa  = r_h1;
                lk_wd   = r_h2;
                fl_wd   = r_wr ? DF_NEXT : DF_NEXT_WRITE;
                n_state = ST_W2;
            end
            ST_W2: begin
                lk_we   = 1'b1;
                fl_we   = 1'b1;
                mem_wa  = r_h2;
                lk_wd   = '0;
                fl_wd   = DF_WRITE;
                head_we = 1'b1;
                n_busy[r_slot] = 1'b1;
                n_avail = r_avail + 16'd1;
                n_step  = '0;
                n_state = ST_EMIT;
            end
            // five submit words
            ST_EMIT: begin
                if (can_load) begin
                    n_out              = '0;
                    n_ovalid           = 1'b1;
                    n_out.request_type = r_wr;
                    n_out.request_slot = r_slot;
                    n_step             = r_step + 3'd1;
                    unique case (r_step)
                        3'd0: begin
                            n_out.result_kind = RK_HEADER;
                            n_out.desc_index  = r_h0;
                            n_out.buf_addr    = r_sector;
                        end
                        3'd1: begin
                            n_out.result_kind = RK_DESC;
                            n_out.desc_index  = r_h0;
                            n_out.buf_addr    = r_hdr_base + {56'd0, r_slot, 4'd0};
                            n_out.buf_len     = 32'd16;
                            n_out.desc_flags  = DF_NEXT;
                            n_out.next_index  = r_h1;
                        end
                        3'd2: begin
                            n_out.result_kind = RK_DESC;
                            n_out.desc_index  = r_h1;
                            n_out.buf_addr    = r_daddr;
                            n_out.buf_len     = r_dlen;
                            n_out.desc_flags  = r_wr ? DF_NEXT : DF_NEXT_WRITE;
                            n_out.next_index  = r_h2;
                        end
                        3'd3: begin
                            n_out.result_kind = RK_DESC;
                            n_out.desc_index  = r_h2;
                            n_out.buf_addr    = r_sts_base + {{(64-SLOT_W){1'b0}}, r_slot};
                            n_out.buf_len     = 32'd1;
                            n_out.desc_flags  = DF_WRITE;
                        end
                        default: begin
                            n_out.result_kind   = RK_AVAIL;
                            n_out.desc_index    = r_h0;
                            n_out.ring_position = r_avail;
                            n_out.last          = 1'b1;
                            n_state             = ST_IDLE;
                        end
                    endcase
                end
            end
            // one descriptor back onto the free list per cycle
            ST_FWALK: begin
                lk_we       = 1'b1;
                mem_wa      = r_walk;
                lk_wd       = r_flist_top;
                n_flist_top = r_walk;
                if (r_free_cnt < r_qsz) begin
                    n_free_cnt = r_free_cnt + CNT_W'(1);
                end
                if (r_fl_q[0] && r_steps != IDX_W'(QUEUE_DEPTH - 1)) begin
                    n_walk  = lk_rd;
                    mem_ra  = lk_rd;
                    n_steps = r_steps + IDX_W'(1);
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (can_load) begin
                    n_out               = '0;
                    n_ovalid            = 1'b1;
                    n_out.result_kind   = RK_DONE;
                    n_out.desc_index    = r_h0;
                    n_out.request_slot  = r_slot;
                    n_out.io_error      = r_err;
                    n_out.ring_position = r_used;
                    n_out.last          = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_SWEEP;
                n_sweep = '0;
            end
        endcase

        // chain head of a completion is kept in r_h0
        if (r_state == ST_IDLE && in_acc && i_req.opcode == OP_COMPLETE) begin
            n_h0 = i_req.used_id;
        end

        // configuration writes; queue_size restarts the queue
        if (cfg_we) begin
            priority case (cfg_idx)
                REG_QUEUE_SIZE: begin
                    n_qsz_raw   = pwdata[CNT_W-1:0];
                    n_qsz       = wr_clamp;
                    n_free_cnt  = wr_clamp;
                    n_flist_top = '0;
                    n_busy      = '0;
                    n_sweep     = '0;
                    n_state     = ST_SWEEP;
                end
                REG_HEADER_BASE: n_hdr_base = pwdata;
                REG_STATUS_BASE: n_sts_base = pwdata;
                default: ;
            endcase
        end
    end

    // descriptor RAMs: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (lk_we) begin
            lk_mem[mem_wa] <= lk_wd;
        end
        r_lk_q  <= lk_mem[mem_ra];
        r_fwd   <= lk_we && (mem_wa == mem_ra);
        r_fwd_d <= lk_wd;
    end

    always_ff @(posedge i_clk) begin
        if (fl_we) begin
            fl_mem[mem_wa] <= fl_wd;
        end
        r_fl_q <= fl_mem[mem_ra];
    end

    // slot heads
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_slot_head[r_slot] <= r_h0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_qsz_raw   <= CNT_W'(QUEUE_DEPTH);
            r_qsz       <= CNT_W'(QUEUE_DEPTH);
            r_hdr_base  <= '0;
            r_sts_base  <= '0;
            r_flist_top <= '0;
            r_free_cnt  <= CNT_W'(QUEUE_DEPTH);
            r_avail     <= '0;
            r_used      <= '0;
            r_busy      <= '0;
            r_sweep     <= '0;
            r_ovalid    <= 1'b0;
            r_step      <= '0;
            r_steps     <= '0;
        end else begin
            r_state     <= n_state;
            r_qsz_raw   <= n_qsz_raw;
            r_qsz       <= n_qsz;
            r_hdr_base  <= n_hdr_base;
            r_sts_base  <= n_sts_base;
            r_flist_top <= n_flist_top;
            r_free_cnt  <= n_free_cnt;
            r_avail     <= n_avail;
            r_used      <= n_used;
            r_busy      <= n_busy;
            r_sweep     <= n_sweep;
            r_ovalid    <= n_ovalid;
            r_step      <= n_step;
            r_steps     <= n_steps;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_h0     <= n_h0;
        r_h1     <= n_h1;
        r_h2     <= n_h2;
        r_slot   <= n_slot;
        r_wr     <= n_wr;
        r_sector <= n_sector;
        r_daddr  <= n_daddr;
        r_dlen   <= n_dlen;
        r_walk   <= n_walk;
        r_err    <= n_err;
        r_out    <= n_out;
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.result_kind   = r_out.result_kind;
    assign o_rsp.desc_index    = r_out.desc_index;
    assign o_rsp.buf_addr      = r_out.buf_addr;
    assign o_rsp.buf_len       = r_out.buf_len;
    assign o_rsp.desc_flags    = r_out.desc_flags;
    assign o_rsp.next_index    = r_out.next_index;
    assign o_rsp.request_type  = r_out.request_type;
    assign o_rsp.request_slot  = r_out.request_slot;
    assign o_rsp.io_error      = r_out.io_error;
    assign o_rsp.ring_position = r_out.ring_position;
    assign o_rsp.last          = r_out.last;

endmodule
